### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, checked outside reset.
`define SVL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication that also holds while reset is applied.
`define SVL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/slist_pkg.sv
package slist_pkg;

    localparam int CAPACITY    = 16;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int OUT_DATA_W  = ((VAL_W + CNT_W + 1 + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic {
        BK_RUN  = 1'b0,
        BK_DUMP = 1'b1
    } t_bk_state;

    // Classified request as it waits in the queue
    typedef struct packed {
        t_op                     op;
        logic                    adds;   // append or sorted insert
        logic signed [VAL_W-1:0] value;
    } t_req;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        t_req req;
    } t_q_head;

endpackage

### rtl/slist_front.sv
module slist_front
    import slist_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VAL_W-1:0]   i_s_tdata,
    input  logic [OP_W-1:0]    i_s_tuser,
    output t_q_head            o_head,
    input  logic               i_pop
);

    t_req               r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QFILL_W-1:0] n_fill;
    logic               push;
    logic               pop;
    t_req               req_in;

    assign o_s_tready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_pop && (r_fill != '0);

    // Classify the opcode on entry
    always_comb begin
        req_in.op    = t_op'(i_s_tuser);
        req_in.adds  = (t_op'(i_s_tuser) == OP_APPEND) || (t_op'(i_s_tuser) == OP_INSERT);
        req_in.value = $signed(i_s_tdata);
    end

    always_comb begin
        n_wr_ptr = push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = QFILL_W'(r_fill + 1'b1);
        end else if (pop && !push) begin
            n_fill = QFILL_W'(r_fill - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= req_in;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.req   = r_queue[r_rd_ptr];

endmodule

### rtl/slist_back.sv
module slist_back
    import slist_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_q_head                 i_head,
    output logic                    o_pop,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output t_status                 o_status,
    output logic signed [VAL_W-1:0] o_entry_value,
    output logic [CNT_W-1:0]        o_entry_count,
    output logic                    o_is_empty,
    output logic                    o_last
);

    logic signed [VAL_W-1:0] r_cells [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_idx;
    t_bk_state               r_state;
    t_bk_state               n_state;
    logic                    r_out_valid;
    t_status                 r_status;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_last;

    logic signed [VAL_W-1:0] ins_cells [CAPACITY];
    logic signed [VAL_W-1:0] rem_cells [CAPACITY];
    logic                    found;
    logic                    full;
    logic                    out_free;
    logic                    dump_end;
    logic                    load;
    logic                    cells_we;
    logic [CNT_W-1:0]        n_count;
    logic [IDX_W-1:0]        n_idx;
    t_status                 res_status;
    logic signed [VAL_W-1:0] res_value;
    logic                    res_last;

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign out_free = !r_out_valid || i_m_tready;
    assign dump_end = (CNT_W'({1'b0, r_idx} + 1'b1) == r_count);

    // Every cell compares against the request value in parallel; prefix ORs
    // turn the hits into a shift mask.
    always_comb begin
        logic seen_ge;
        logic seen_eq;
        logic any_ge;
        logic valid_c;
        logic hit_ge;
        logic hit_eq;
        logic at_pos;
        any_ge  = 1'b0;
        seen_ge = 1'b0;
        seen_eq = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            valid_c = (CNT_W'(i) < r_count);
            any_ge  = any_ge || (valid_c && (i_head.req.op == OP_INSERT)
                                 && !(r_cells[i] < i_head.req.value));
        end
        for (int i = 0; i < CAPACITY; i++) begin
            valid_c = (CNT_W'(i) < r_count);
            hit_ge  = valid_c && (i_head.req.op == OP_INSERT)
                      && !(r_cells[i] < i_head.req.value);
            hit_eq  = valid_c && (r_cells[i] == i_head.req.value);
            at_pos  = (hit_ge && !seen_ge) || (!any_ge && (CNT_W'(i) == r_count));
            if (seen_ge && i > 0) begin
                ins_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
            end else if (at_pos) begin
                ins_cells[i] = i_head.req.value;
            end else begin
                ins_cells[i] = r_cells[i];
            end
            seen_eq = seen_eq || hit_eq;
            if (seen_eq && i < CAPACITY - 1) begin
                rem_cells[i] = r_cells[(i < CAPACITY - 1) ? i + 1 : i];
            end else begin
                rem_cells[i] = r_cells[i];
            end
            seen_ge = seen_ge || hit_ge;
        end
        found = seen_eq;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN: begin
                if (i_head.valid && out_free && i_head.req.op == OP_DUMP
                    && r_count != '0) begin
                    n_state = BK_DUMP;
                end
            end
            BK_DUMP: begin
                if (out_free && dump_end) begin
                    n_state = BK_RUN;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    // Actions per state
    always_comb begin
        o_pop      = 1'b0;
        load       = 1'b0;
        cells_we   = 1'b0;
        n_count    = r_count;
        n_idx      = r_idx;
        res_status = ST_OK;
        res_value  = '0;
        res_last   = 1'b1;
        case (r_state)
            BK_RUN: begin
                if (i_head.valid && out_free) begin
                    case (i_head.req.op)
                        OP_APPEND, OP_INSERT: begin
                            load  = 1'b1;
                            o_pop = 1'b1;
                            if (full) begin
                                res_status = ST_FULL;
                            end else begin
                                cells_we = 1'b1;
                                n_count  = CNT_W'(r_count + 1'b1);
                            end
                        end
                        OP_REMOVE: begin
                            load  = 1'b1;
                            o_pop = 1'b1;
                            if (found) begin
                                cells_we = 1'b1;
                                n_count  = CNT_W'(r_count - 1'b1);
                            end else begin
                                res_status = ST_NOT_FOUND;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                load       = 1'b1;
                                o_pop      = 1'b1;
                                res_status = ST_EMPTY;
                            end else begin
                                n_idx = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_DUMP: begin
                if (out_free) begin
                    load      = 1'b1;
                    res_value = r_cells[r_idx];
                    res_last  = dump_end;
                    if (dump_end) begin
                        o_pop = 1'b1;
                    end else begin
                        n_idx = IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cells_we) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cells[i] <= i_head.req.adds ? ins_cells[i] : rem_cells[i];
            end
        end
        if (load) begin
            r_status    <= res_status;
            r_value     <= res_value;
            r_out_count <= n_count;
            r_last      <= res_last;
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = (r_out_count == '0);
    assign o_last        = r_last;

endmodule

### rtl/sorted_value_list_top.sv
// Bounded ordered list of signed 32-bit values (16 entries). A request
// carries an opcode in s_tuser (append, sorted insert, remove first equal,
// dump) and a value in s_tdata. Append, insert and remove give one result
// each from the cell array, where every entry compares against the value
// and shifts in parallel; a queue of two requests sits in front, so a
// steady stream of these runs at one request per cycle while results are
// taken. A dump first starts the read-out, then gives one entry per cycle
// from the cells while results are taken, the final one flagged on
// m_tlast; a dump of an empty list gives a single result with status
// empty. Every result reports the entry count and the empty flag as they
// stand after the operation. An insert into a full list is dropped with
// status full, and a remove that finds nothing reports not found; neither
// changes the list. Results wait in an output register, so the input side
// keeps filling the queue while the master side stalls.
module sorted_value_list_top
    import slist_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VAL_W-1:0]      i_s_tdata,    // [31:0] value
    input  logic [OP_W-1:0]       i_s_tuser,    // [1:0] opcode
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,    // [31:0] entry_value, [36:32] entry_count,
                                                // [37] is_empty, rest zero
    output logic [ST_W-1:0]       o_m_tuser,    // [1:0] status
    output logic                  o_m_tlast     // last result of the request
);

    t_q_head                 head;
    logic                    pop;
    t_status                 status;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;

    // Accept and classify requests, hold them in the queue
    slist_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Cell array, dump sequencer and output register
    slist_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_status      (status),
        .o_entry_value (entry_value),
        .o_entry_count (entry_count),
        .o_is_empty    (is_empty),
        .o_last        (o_m_tlast)
    );

    // Pack the result fields, lowest field first, pad to whole bytes
    assign o_m_tdata = OUT_DATA_W'({is_empty, entry_count, entry_value});
    assign o_m_tuser = status;

endmodule

### rtl/slist_checker.sv
`include "assert_macros.svh"

module slist_checker
    import slist_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [ST_W-1:0]       o_m_tuser,
    input logic                  o_m_tlast
);

    logic                       m_stall;
    logic                       m_mid;
    logic [OUT_DATA_W+ST_W:0]   m_beat;
    logic [CNT_W-1:0]           m_count;
    logic                       m_empty;
    logic                       m_flag_ok;
    logic                       m_count_ok;
    logic                       m_mid_ok;

    // Split the result beat into the fields the checks look at
    assign m_stall    = o_m_tvalid && !i_m_tready;
    assign m_mid      = o_m_tvalid && !o_m_tlast;
    assign m_beat     = {o_m_tlast, o_m_tuser, o_m_tdata};
    assign m_count    = o_m_tdata[VAL_W+CNT_W-1:VAL_W];
    assign m_empty    = o_m_tdata[VAL_W+CNT_W];
    assign m_flag_ok  = (m_empty == (m_count == '0));
    assign m_count_ok = (m_count <= CNT_W'(CAPACITY));
    assign m_mid_ok   = (o_m_tuser == ST_OK) && (m_count != '0);

    // A stalled result holds
    `SVL_ASSERT(a_out_hold, i_clk, i_rst_n, m_stall |=> o_m_tvalid && $stable(m_beat), "stall moved")

    // Empty flag follows the count
    `SVL_ASSERT(a_empty_flag, i_clk, i_rst_n, o_m_tvalid |-> m_flag_ok, "empty flag disagrees")

    // Count never exceeds capacity
    `SVL_ASSERT(a_count_bound, i_clk, i_rst_n, o_m_tvalid |-> m_count_ok, "count above capacity")

    // Only dump entries come without last, and they are ok
    `SVL_ASSERT(a_mid_ok, i_clk, i_rst_n, m_mid |-> m_mid_ok, "non-final result with bad status")

    // Nothing is shown during reset
    `SVL_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind sorted_value_list_top slist_checker u_slist_checker (.*);

### verif/tb_top.sv
module tb_top;
    import slist_pkg::*;

    localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
    localparam int               LONG_HOLD = 60;
    localparam int               TAIL_WAIT = 40;

    // One result as it leaves the master side
    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             last;
    } t_list_result;

    // Directed request; typed rows carry their single result written out by hand
    typedef struct {
        t_op              op;
        logic [VAL_W-1:0] value;
        int               reps;
        bit               typed;
        t_status          status;
        int               count;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [VAL_W-1:0]      i_s_tdata;    // [31:0] value
    logic [OP_W-1:0]       i_s_tuser;    // [1:0] opcode
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;    // [31:0] entry_value, [36:32] entry_count,
                                         // [37] is_empty, rest zero
    logic [ST_W-1:0]       o_m_tuser;    // [1:0] status
    logic                  o_m_tlast;

    // Shadow copy of the list and the results still owed by the block
    logic signed [VAL_W-1:0] shadow_list[$];
    t_list_result            due_results[$];

    int n_faults;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    bit long_hold_req;
    bit long_hold_done;

    t_plan_row plan [13] = '{
        '{OP_DUMP,   32'd0,       1,  1'b1, ST_EMPTY,     0},
        '{OP_REMOVE, 32'd5,       1,  1'b1, ST_NOT_FOUND, 0},
        '{OP_APPEND, -32'sd100,   1,  1'b1, ST_OK,        1},
        '{OP_INSERT, VAL_MIN,     1,  1'b1, ST_OK,        2},
        '{OP_INSERT, VAL_MAX,     1,  1'b1, ST_OK,        3},   // lands at the tail
        '{OP_APPEND, 32'd5,       1,  1'b1, ST_OK,        4},   // tail must follow it
        '{OP_DUMP,   32'hFFFF_FFFF, 1, 1'b0, ST_OK,       0},
        '{OP_INSERT, 32'd0,       1,  1'b0, ST_OK,        0},
        '{OP_REMOVE, VAL_MAX,     1,  1'b0, ST_OK,        0},
        '{OP_REMOVE, 32'd99,      1,  1'b1, ST_NOT_FOUND, 4},
        '{OP_INSERT, 32'hFFFF_FFFF, 12, 1'b0, ST_OK,      0},   // duplicates up to full
        '{OP_APPEND, 32'd1,       1,  1'b1, ST_FULL,      16},
        '{OP_INSERT, 32'd1,       1,  1'b1, ST_FULL,      16}
    };

    sorted_value_list_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void owe_result(t_status st, logic [VAL_W-1:0] val, logic last);
        t_list_result r;
        r.status = st;
        r.value  = val;
        r.count  = CNT_W'(shadow_list.size());
        r.empty  = (shadow_list.size() == 0);
        r.last   = last;
        due_results.push_back(r);
    endfunction

    // Apply one request to the shadow list and queue the results it owes
    function automatic void apply_to_shadow_list(t_op op, logic signed [VAL_W-1:0] v);
        int pos;
        int n;
        n = shadow_list.size();
        case (op)
            OP_APPEND, OP_INSERT: begin
                if (n >= CAPACITY) begin
                    owe_result(ST_FULL, '0, 1'b1);
                end else begin
                    pos = n;
                    if (op == OP_INSERT) begin
                        for (pos = 0; pos < n; pos++)
                            if (!(shadow_list[pos] < v))
                                break;
                    end
                    shadow_list.insert(pos, v);
                    owe_result(ST_OK, '0, 1'b1);
                end
            end
            OP_REMOVE: begin
                for (pos = 0; pos < n; pos++)
                    if (shadow_list[pos] == v)
                        break;
                if (pos >= n) begin
                    owe_result(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    shadow_list.delete(pos);
                    owe_result(ST_OK, '0, 1'b1);
                end
            end
            default: begin
                if (n == 0)
                    owe_result(ST_EMPTY, '0, 1'b1);
                for (pos = 0; pos < n; pos++)
                    owe_result(ST_OK, shadow_list[pos], pos == n - 1);
            end
        endcase
    endfunction

    // Offer one request from a falling edge and hold it until accepted
    task automatic send_request(t_op op, logic [VAL_W-1:0] v, bit typed, t_status st, int cnt);
        int owed_before;
        t_list_result r;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = op;
        i_s_tdata  = v;
        do @(posedge i_clk); while (!o_s_tready);
        owed_before = due_results.size();
        apply_to_shadow_list(op, v);
        if (typed) begin
            // Swap the predicted result for the hand-written one
            while (due_results.size() > owed_before)
                void'(due_results.pop_back());
            r.status = st;
            r.value  = '0;
            r.count  = CNT_W'(cnt);
            r.empty  = (cnt == 0);
            r.last   = 1'b1;
            due_results.push_back(r);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(bit from_list);
        int n;
        n = shadow_list.size();
        if (from_list && n > 0 && $urandom_range(3) != 0)
            return shadow_list[$urandom_range(n - 1)];
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return VAL_W'($urandom_range(16)) - 32'd8;
            5, 6, 7:       return $urandom;
            8: begin
                case ($urandom_range(3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:       return $urandom;
        endcase
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left  = hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            i_m_tready     = 1'b0;
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
        end else begin
            i_m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check each accepted result against the oldest owed one
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (due_results.size() == 0) begin
                n_faults++;
                $display("%0t: unexpected result status=%0d value=%h count=%0d empty=%b last=%b",
                         $time, o_m_tuser, o_m_tdata[31:0], o_m_tdata[36:32],
                         o_m_tdata[37], o_m_tlast);
            end else begin
                exp_r = due_results.pop_front();
                if (o_m_tuser !== exp_r.status || o_m_tdata[31:0] !== exp_r.value ||
                    o_m_tdata[36:32] !== exp_r.count || o_m_tdata[37] !== exp_r.empty ||
                    o_m_tlast !== exp_r.last || o_m_tdata[OUT_DATA_W-1:38] !== '0) begin
                    n_faults++;
                    $display("%0t: mismatch exp status=%0d value=%h count=%0d empty=%b last=%b",
                             $time, exp_r.status, exp_r.value, exp_r.count, exp_r.empty,
                             exp_r.last);
                    $display("%0t:          got status=%0d value=%h count=%0d empty=%b last=%b pad=%b",
                             $time, o_m_tuser, o_m_tdata[31:0], o_m_tdata[36:32],
                             o_m_tdata[37], o_m_tlast, o_m_tdata[OUT_DATA_W-1:38]);
                end
            end
        end
    end

    initial begin
        t_op op;
        bit  filling;
        int  roll;
        n_faults       = 0;
        tx_idle_pct    = 37;
        rx_idle_pct    = 84;
        hold_left      = 0;
        long_hold_req  = 1'b0;
        long_hold_done = 1'b0;
        filling        = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_APPEND;
        i_m_tready     = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty list, extremes, tail handling, duplicates, full list
        foreach (plan[k])
            for (int j = 0; j < plan[k].reps; j++)
                send_request(plan[k].op, plan[k].value, plan[k].typed, plan[k].status,
                             plan[k].count);
        send_request(OP_DUMP, '0, 1'b0, ST_OK, 0);

        // Random: drift between filling up and draining so both ends are hit often
        for (int n = 0; n < 290; n++) begin
            if (n == 95) begin
                tx_idle_pct = 84;
                rx_idle_pct = 37;
            end
            if (n == 190) begin
                tx_idle_pct   = 0;
                rx_idle_pct   = 0;
                long_hold_req = 1'b1;   // let the block back up against its input
            end
            if (filling && shadow_list.size() == CAPACITY && $urandom_range(2) == 0)
                filling = 1'b0;
            if (!filling && shadow_list.size() == 0 && $urandom_range(2) == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            if (roll < 12)
                op = OP_DUMP;
            else if (filling)
                op = (roll < 56) ? OP_APPEND : (roll < 85) ? OP_INSERT : OP_REMOVE;
            else
                op = (roll < 21) ? OP_APPEND : (roll < 30) ? OP_INSERT : OP_REMOVE;
            send_request(op, pick_value(op != OP_APPEND), 1'b0, ST_OK, 0);
        end
        i_s_tvalid = 1'b0;

        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (n_faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/slist_pkg.sv
rtl/slist_front.sv
rtl/slist_back.sv
rtl/sorted_value_list_top.sv
rtl/slist_checker.sv
verif/tb_top.sv
